### hdl/assert_macros.svh
// Assertion macros used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/rhc_pkg.sv
// Types, constants and the divider step for the RGB to HSV converter.
package rhc_pkg;

  localparam int unsigned CH_W      = 8;
  localparam int unsigned HUE_W     = 9;
  localparam int unsigned PCT_W     = 7;
  localparam int unsigned NUM_W     = 17;   // widest dividend: blue sector hue
  localparam int unsigned QUO_W     = 9;    // widest quotient: hue before wrap
  localparam int unsigned DIV_STEPS = QUO_W;

  localparam logic [HUE_W-1:0] HUE_FULL = 9'd360;
  localparam logic [NUM_W-1:0] K60      = 17'd60;
  localparam logic [NUM_W-1:0] K100     = 17'd100;
  localparam logic [NUM_W-1:0] K120     = 17'd120;
  localparam logic [NUM_W-1:0] K240     = 17'd240;

  typedef struct packed {
    logic [CH_W-1:0] red_in;
    logic [CH_W-1:0] green_in;
    logic [CH_W-1:0] blue_in;
  } pixel_t;

  typedef struct packed {
    logic [HUE_W-1:0] hue_deg;
    logic [PCT_W-1:0] saturation_pct;
    logic [PCT_W-1:0] brightness_pct;
  } hsv_t;

  // One restoring divider lane: partial remainder, quotient so far, divisor.
  typedef struct packed {
    logic [NUM_W-1:0] rem;
    logic [QUO_W-1:0] quo;
    logic [CH_W-1:0]  dsr;
  } div_lane_t;

  typedef struct packed {
    div_lane_t        hue;
    div_lane_t        sat;
    logic [PCT_W-1:0] bri;    // finished in the prep stage
    logic             wrap;   // red sector, negative hue: result is 360 - quotient
    logic             grey;   // zero chroma
  } div_stage_t;

  // Resolve one quotient bit; bit_pos is a constant at every call site.
  function automatic div_lane_t div_step(div_lane_t lane, int unsigned bit_pos);
    div_lane_t        res;
    logic [NUM_W-1:0] shifted;
    res     = lane;
    shifted = NUM_W'(lane.dsr) << bit_pos;
    if (lane.rem >= shifted) begin
      res.rem = lane.rem - shifted;
      res.quo = lane.quo | (QUO_W'(1) << bit_pos);
    end
    return res;
  endfunction

endpackage

### hdl/rgb_to_hsv_convert_unit.sv
// RGB to HSV converter: pipelined, one pixel per clock unless the output stalls.
//
//  channel | ports                           | payload
//  --------+---------------------------------+----------------------------
//  input   | in_valid, in_ready, in_data     | rhc_pkg::pixel_t (r, g, b)
//  output  | out_valid, out_ready, out_data  | rhc_pkg::hsv_t (h, s, v)
//
// The pipeline is one prep stage (max/min, sector numerators, brightness),
// nine restoring divider stages resolving one hue and saturation quotient bit
// each, and the output register. It takes one pixel per cycle unless stalled.
// Reset (rst_n low, synchronous) empties every stage; payload is not reset.
// Each stage advances when it is empty or its successor advances, so bubbles
// collapse and a stalled output still lets upstream stages fill.
`include "assert_macros.svh"

module rgb_to_hsv_convert_unit (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  rhc_pkg::pixel_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output rhc_pkg::hsv_t   out_data
);

  localparam int unsigned NS = rhc_pkg::DIV_STEPS + 1;

  // Prep: channel max/min and dividends
  logic [rhc_pkg::CH_W-1:0]  r_c, g_c, b_c, mx_c, mn_c, delta_c;
  logic [rhc_pkg::NUM_W-1:0] hue_num_c;
  logic [rhc_pkg::NUM_W-1:0] bri_num_c;
  logic                      wrap_c;
  rhc_pkg::div_stage_t       prep_c;

  always_comb begin
    r_c     = in_data.red_in;
    g_c     = in_data.green_in;
    b_c     = in_data.blue_in;
    mx_c    = (r_c > g_c) ? r_c : g_c;
    mn_c    = (r_c < g_c) ? r_c : g_c;
    if (b_c > mx_c) mx_c = b_c;
    if (b_c < mn_c) mn_c = b_c;
    delta_c = mx_c - mn_c;
    wrap_c  = 1'b0;

    if (r_c == mx_c) begin
      if (g_c >= b_c) begin
        hue_num_c = rhc_pkg::K60 * rhc_pkg::NUM_W'(g_c - b_c);
      end else begin
        // ceiling division of the negative part, subtracted from 360 later
        hue_num_c = rhc_pkg::K60 * rhc_pkg::NUM_W'(b_c - g_c)
                  + rhc_pkg::NUM_W'(delta_c) - rhc_pkg::NUM_W'(1);
        wrap_c    = 1'b1;
      end
    end else if (g_c == mx_c) begin
      hue_num_c = rhc_pkg::K120 * rhc_pkg::NUM_W'(delta_c)
                + rhc_pkg::K60 * rhc_pkg::NUM_W'(b_c)
                - rhc_pkg::K60 * rhc_pkg::NUM_W'(r_c);
    end else begin
      hue_num_c = rhc_pkg::K240 * rhc_pkg::NUM_W'(delta_c)
                + rhc_pkg::K60 * rhc_pkg::NUM_W'(r_c)
                - rhc_pkg::K60 * rhc_pkg::NUM_W'(g_c);
    end

    // x / 255 == (x + (x >> 8) + 1) >> 8 for x below 65535
    bri_num_c = rhc_pkg::K100 * rhc_pkg::NUM_W'(mx_c);

    prep_c.hue.rem = hue_num_c;
    prep_c.hue.quo = '0;
    prep_c.hue.dsr = delta_c;
    prep_c.sat.rem = rhc_pkg::K100 * rhc_pkg::NUM_W'(delta_c);
    prep_c.sat.quo = '0;
    prep_c.sat.dsr = mx_c;
    prep_c.bri     = rhc_pkg::PCT_W'((bri_num_c + (bri_num_c >> 8)
                                      + rhc_pkg::NUM_W'(1)) >> 8);
    prep_c.wrap    = wrap_c;
    prep_c.grey    = (delta_c == '0);
  end

  // Stage registers
  logic [NS-1:0]       vld_r;
  rhc_pkg::div_stage_t stg_r [NS];
  logic [NS-1:0]       stg_ready;
  logic                out_valid_r;
  rhc_pkg::hsv_t       out_data_r;
  logic                out_adv;
  rhc_pkg::hsv_t       final_c;

  assign out_adv  = !out_valid_r || out_ready;
  assign in_ready = stg_ready[0];

  for (genvar i = 0; i < NS; i++) begin : g_stage
    logic                src_valid;
    rhc_pkg::div_stage_t src_data;

    if (i == NS - 1) begin : g_last
      assign stg_ready[i] = !vld_r[i] || out_adv;
    end else begin : g_mid
      assign stg_ready[i] = !vld_r[i] || stg_ready[i+1];
    end

    if (i == 0) begin : g_src_in
      assign src_valid = in_valid;
      assign src_data  = prep_c;
    end else begin : g_src_div
      // stage i resolves quotient bit QUO_W - i
      always_comb begin
        src_valid      = vld_r[i-1];
        src_data       = stg_r[i-1];
        src_data.hue   = rhc_pkg::div_step(stg_r[i-1].hue, rhc_pkg::QUO_W - i);
        src_data.sat   = rhc_pkg::div_step(stg_r[i-1].sat, rhc_pkg::QUO_W - i);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (stg_ready[i]) begin
        vld_r[i] <= src_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (stg_ready[i]) begin
        stg_r[i] <= src_data;
      end
    end
  end

  // Final assembly: hue wrap and grey override
  always_comb begin
    final_c.hue_deg        = stg_r[NS-1].hue.quo;
    if (stg_r[NS-1].wrap) begin
      final_c.hue_deg = rhc_pkg::HUE_FULL - stg_r[NS-1].hue.quo;
    end
    final_c.saturation_pct = stg_r[NS-1].sat.quo[rhc_pkg::PCT_W-1:0];
    final_c.brightness_pct = stg_r[NS-1].bri;
    if (stg_r[NS-1].grey) begin
      final_c.hue_deg        = '0;
      final_c.saturation_pct = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= vld_r[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv) begin
      out_data_r <= final_c;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks
  `ASSERT_IMPLIES(a_div_done, vld_r[NS-1] && !stg_r[NS-1].grey,
    (stg_r[NS-1].hue.rem < stg_r[NS-1].hue.dsr) &&
    (stg_r[NS-1].sat.rem < stg_r[NS-1].sat.dsr), "divider remainder not reduced")
  `ASSERT_IMPLIES(a_out_range, out_valid,
    (out_data.hue_deg < rhc_pkg::HUE_FULL) && (out_data.saturation_pct <= 7'd100) &&
    (out_data.brightness_pct <= 7'd100), "result out of range")
  `ASSERT_NEXT(a_stall_hold, out_valid && !out_ready && vld_r[NS-1],
    vld_r[NS-1] && out_valid, "transaction lost in last stage under stall")

endmodule
